/* hdl/tsplit_pkg.sv */
// Shared types, codes and character constants of the C source token splitter.
// No dependencies; every other file imports this package.
package tsplit_pkg;

   localparam int FifoDepth = 4;
   localparam int FifoPtrW  = $clog2(FifoDepth);
   localparam int FifoCntW  = $clog2(FifoDepth + 1);
   localparam int LimitW    = 9;

   localparam logic [LimitW-1:0] TOKEN_LIMIT_RESET = 9'd100;
   localparam logic [LimitW-1:0] TOKEN_LIMIT_MIN   = 9'd2;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_WORD   = 3'd1,
      MODE_NUMBER = 3'd2,
      MODE_STRING = 3'd3,
      MODE_SLASH  = 3'd4,
      MODE_LINE   = 3'd5,
      MODE_BLOCK  = 3'd6
   } mode_type;

   localparam logic [2:0] KIND_WORD   = 3'd0;
   localparam logic [2:0] KIND_NUMBER = 3'd1;
   localparam logic [2:0] KIND_STRING = 3'd2;
   localparam logic [2:0] KIND_SINGLE = 3'd3;
   localparam logic [2:0] KIND_END    = 3'd4;

   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_NUL    = 8'h00;

   typedef struct packed {
      mode_type          mode;
      logic [7:0]        held_char;
      logic              held_valid;
      logic [2:0]        held_kind;
      logic [7:0]        prev_char;
      logic              quote_single;
      logic [LimitW-1:0] tok_len;
   } scan_state_type;

   localparam scan_state_type SCAN_RESET = '{
      mode:         MODE_IDLE,
      held_char:    8'd0,
      held_valid:   1'b0,
      held_kind:    3'd0,
      prev_char:    8'd0,
      quote_single: 1'b0,
      tok_len:      9'd0
   };

   typedef struct packed {
      logic [7:0] char_out;
      logic [2:0] token_kind;
      logic       token_end;
   } result_type;

   // Up to two result beats per source character
   typedef struct packed {
      logic [1:0] count;
      result_type item1;
      result_type item0;
   } result_pair_type;

   typedef struct packed {
      logic [FifoCntW-1:0] fill;
      logic                has_room;
   } fifo_status_type;

endpackage

/* hdl/tsplit_step.sv */
// Per-character scanner decision: next scan state and the result beats caused.
// Depends on tsplit_pkg.
module tsplit_step (
   input  tsplit_pkg::scan_state_type  state_i,
   input  logic [7:0]                  char_i,
   input  logic                        eoi_i,
   input  logic [tsplit_pkg::LimitW-1:0] limit_i,
   output tsplit_pkg::scan_state_type  next_state_o,
   output tsplit_pkg::result_pair_type results_o
);
   import tsplit_pkg::*;

   typedef struct packed {
      scan_state_type  st;
      result_pair_type res;
   } work_type;

   logic [LimitW-1:0] thr;
   work_type          w;
   logic [7:0]        quote_char;
   logic              str_closes;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
             (c == CH_UNDER) || (c == CH_DOT);
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
             (c == CH_FF) || (c == CH_CR);
   endfunction

   function automatic result_pair_type push(input result_pair_type r, input logic [7:0] ch,
                                            input logic [2:0] k, input logic e);
      result_pair_type o;
      o = r;
      if (r.count == 2'd0) begin
         o.item0.char_out   = ch;
         o.item0.token_kind = k;
         o.item0.token_end  = e;
      end else begin
         o.item1.char_out   = ch;
         o.item1.token_kind = k;
         o.item1.token_end  = e;
      end
      o.count = r.count + 2'd1;
      return o;
   endfunction

   // Add a character to the token in progress; close it on request or at the limit
   function automatic work_type take(input work_type wi, input logic [7:0] ch,
                                     input logic [2:0] k, input logic closes,
                                     input logic [LimitW-1:0] t);
      work_type o;
      o = wi;
      if (wi.st.held_valid) begin
         o.res = push(o.res, wi.st.held_char, wi.st.held_kind, 1'b0);
      end
      o.st.tok_len = wi.st.tok_len + 9'd1;
      if (closes || (o.st.tok_len >= t)) begin
         o.res           = push(o.res, ch, k, 1'b1);
         o.st.held_valid = 1'b0;
         o.st.mode       = MODE_IDLE;
         o.st.tok_len    = '0;
      end else begin
         o.st.held_char  = ch;
         o.st.held_kind  = k;
         o.st.held_valid = 1'b1;
      end
      return o;
   endfunction

   // Classify a character that begins a fresh token
   function automatic work_type start(input work_type wi, input logic [7:0] c,
                                      input logic [LimitW-1:0] t);
      work_type o;
      o = wi;
      o.st.held_valid = 1'b0;
      o.st.tok_len    = '0;
      o.st.mode       = MODE_IDLE;
      if (is_blank(c)) begin
         o = o;
      end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
         o.st.mode         = MODE_STRING;
         o.st.quote_single = (c == CH_SQUOTE);
         o.st.prev_char    = c;
         o = take(o, c, KIND_STRING, 1'b0, t);
      end else if (c == CH_SLASH) begin
         o.st.mode = MODE_SLASH;
      end else if (is_digit(c)) begin
         o.st.mode      = MODE_NUMBER;
         o.st.prev_char = c;
         o = take(o, c, KIND_NUMBER, 1'b0, t);
      end else if (is_word(c)) begin
         o.st.mode      = MODE_WORD;
         o.st.prev_char = c;
         o = take(o, c, KIND_WORD, 1'b0, t);
      end else begin
         o.res = push(o.res, c, KIND_SINGLE, 1'b1);
      end
      return o;
   endfunction

   function automatic work_type close_restart(input work_type wi, input logic [7:0] c,
                                              input logic [LimitW-1:0] t);
      work_type o;
      o = wi;
      if (wi.st.held_valid) begin
         o.res = push(o.res, wi.st.held_char, wi.st.held_kind, 1'b1);
      end
      o.st.held_valid = 1'b0;
      o = start(o, c, t);
      return o;
   endfunction

   // Limits below two act as two; a token holds at most limit minus one characters
   assign thr = ((limit_i < TOKEN_LIMIT_MIN) ? TOKEN_LIMIT_MIN : limit_i) - 9'd1;

   assign quote_char = state_i.quote_single ? CH_SQUOTE : CH_DQUOTE;
   assign str_closes = (char_i == quote_char) && (state_i.prev_char != CH_BSLASH);

   always_comb begin
      w.st  = state_i;
      w.res = '0;
      if (eoi_i) begin
         if (state_i.held_valid) begin
            w.res = push(w.res, state_i.held_char, state_i.held_kind, 1'b1);
         end
         if (state_i.mode == MODE_SLASH) begin
            w.res = push(w.res, CH_SLASH, KIND_SINGLE, 1'b1);
         end
         w.res           = push(w.res, CH_NUL, KIND_END, 1'b1);
         w.st.mode       = MODE_IDLE;
         w.st.held_valid = 1'b0;
         w.st.tok_len    = '0;
         w.st.prev_char  = CH_NUL;
      end else begin
         case (state_i.mode)
            MODE_WORD: begin
               if (is_word(char_i)) begin
                  w.st.prev_char = char_i;
                  w = take(w, char_i, KIND_WORD, 1'b0, thr);
               end else begin
                  w = close_restart(w, char_i, thr);
               end
            end
            MODE_NUMBER: begin
               if (is_digit(char_i) || (((char_i == CH_COMMA) || (char_i == CH_DOT)) &&
                                        is_digit(state_i.prev_char))) begin
                  w.st.prev_char = char_i;
                  w = take(w, char_i, KIND_NUMBER, 1'b0, thr);
               end else begin
                  w = close_restart(w, char_i, thr);
               end
            end
            MODE_STRING: begin
               w.st.prev_char = char_i;
               w = take(w, char_i, KIND_STRING, str_closes, thr);
            end
            MODE_SLASH: begin
               if (char_i == CH_SLASH) begin
                  w.st.mode = MODE_LINE;
               end else if (char_i == CH_STAR) begin
                  w.st.mode      = MODE_BLOCK;
                  w.st.prev_char = CH_NUL;
               end else begin
                  w.res = push(w.res, CH_SLASH, KIND_SINGLE, 1'b1);
                  w = start(w, char_i, thr);
               end
            end
            MODE_LINE: begin
               if (char_i == CH_NL) begin
                  w = start(w, char_i, thr);
               end
            end
            MODE_BLOCK: begin
               if ((state_i.prev_char == CH_STAR) && (char_i == CH_SLASH)) begin
                  w.st.mode      = MODE_IDLE;
                  w.st.prev_char = CH_NUL;
               end else begin
                  w.st.prev_char = char_i;
               end
            end
            default: begin
               w = start(w, char_i, thr);
            end
         endcase
      end
   end

   assign next_state_o = w.st;
   assign results_o    = w.res;

endmodule

/* hdl/tsplit_rsp_fifo.sv */
// Result queue: up to two beats in per cycle, one out per cycle on rsp_ready.
// Depends on tsplit_pkg.
module tsplit_rsp_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_en,
   input  tsplit_pkg::result_pair_type   push_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output tsplit_pkg::result_type        rsp_data,
   output tsplit_pkg::fifo_status_type   status
);
   import tsplit_pkg::*;

   result_type          mem_ff [FifoDepth];
   logic [FifoPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FifoCntW-1:0] fill_ff, fill_in;
   logic [FifoPtrW-1:0] wr_ptr_plus1;
   logic [1:0]          n_push;
   logic                pop;

   assign n_push       = push_en ? push_data.count : 2'd0;
   assign pop          = rsp_valid && rsp_ready;
   assign wr_ptr_plus1 = wr_ptr_ff + FifoPtrW'(1);
   assign wr_ptr_in    = wr_ptr_ff + FifoPtrW'(n_push);
   assign rd_ptr_in    = rd_ptr_ff + FifoPtrW'(pop);
   assign fill_in      = fill_ff + FifoCntW'(n_push) - FifoCntW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_data.item0;
      end
      if (n_push == 2'd2) begin
         mem_ff[wr_ptr_plus1] <= push_data.item1;
      end
   end

   assign rsp_valid       = (fill_ff != '0);
   assign rsp_data        = mem_ff[rd_ptr_ff];
   assign status.fill     = fill_ff;
   assign status.has_room = (fill_ff <= FifoCntW'(FifoDepth - 2));

endmodule

/* hdl/c_source_token_splitter_unit.sv */
// C source token splitter: one source byte in per beat, token characters out per beat.
// An accepted request beat goes through the input stage, then the response queue.
// Throughput: one request beat per cycle while the queue has room; a byte that
// yields two response beats (a held character plus the next) sends them one at a time.
// Reset (synchronous, active high): scanner idle, queue empty, token_limit back to 100.
// Depends on tsplit_pkg, tsplit_step and tsplit_rsp_fifo.
module c_source_token_splitter_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_in,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_char_out,
   output logic [2:0] rsp_token_kind,
   output logic       rsp_token_end,
   input  logic       csr_write_en,
   input  logic [8:0] csr_write_data
);
   import tsplit_pkg::*;

   // Configuration register
   logic [LimitW-1:0] token_limit_ff;

   // Input stage: holds one request beat until the queue has room for its results
   logic              stage_valid_ff;
   logic [7:0]        stage_char_ff;
   logic              stage_eoi_ff;

   scan_state_type    state_ff, state_in;
   result_pair_type   step_results;
   result_type        rsp_data;
   fifo_status_type   fifo_status;
   logic              advance;
   logic              req_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         token_limit_ff <= TOKEN_LIMIT_RESET;
      end else if (csr_write_en) begin
         token_limit_ff <= csr_write_data;
      end
   end

   // Advance the staged beat whenever two queue slots are guaranteed free
   assign advance   = stage_valid_ff && fifo_status.has_room;
   assign req_ready = !stage_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_fire) begin
         stage_valid_ff <= 1'b1;
      end else if (advance) begin
         stage_valid_ff <= 1'b0;
      end
   end

   // Payload: no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_char_ff <= req_char_in;
         stage_eoi_ff  <= req_end_of_input;
      end
   end

   tsplit_step u_step (
      .state_i      (state_ff),
      .char_i       (stage_char_ff),
      .eoi_i        (stage_eoi_ff),
      .limit_i      (token_limit_ff),
      .next_state_o (state_in),
      .results_o    (step_results)
   );

   // Scanner state moves only when the staged beat is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCAN_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   tsplit_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (advance),
      .push_data (step_results),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .status    (fifo_status)
   );

   assign rsp_char_out   = rsp_data.char_out;
   assign rsp_token_kind = rsp_data.token_kind;
   assign rsp_token_end  = rsp_data.token_end;

`ifndef SYNTH
   // Queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      fifo_status.fill <= FifoCntW'(FifoDepth))
      else $error("response queue overflow");

   // A held character only exists inside a word, number or string
   assert property (@(posedge clock) disable iff (reset)
      state_ff.held_valid |-> (state_ff.mode == MODE_WORD) ||
                              (state_ff.mode == MODE_NUMBER) ||
                              (state_ff.mode == MODE_STRING))
      else $error("held character outside a token");

   // End of input leaves the scanner idle with nothing held
   assert property (@(posedge clock) disable iff (reset)
      (advance && stage_eoi_ff) |=> (state_ff.mode == MODE_IDLE) && !state_ff.held_valid)
      else $error("scanner not idle after end of input");

   // Every consumed end-of-input beat produces at least its end marker
   assert property (@(posedge clock) disable iff (reset)
      (advance && stage_eoi_ff) |-> (step_results.count != 2'd0))
      else $error("end of input produced no response");
`endif

endmodule

/* bench/tb_top.sv */
// Self-checking bench for c_source_token_splitter_unit: directed and random byte streams.
// Predicts every token character beat in-house; depends on tsplit_pkg and the unit itself.
module tb_top;
   import tsplit_pkg::*;

   localparam int QUIET_LIMIT = 2000; // cycles with no beat on either channel
   localparam int DRAIN_CYCLES = 4;   // settle time after the last due beat
   localparam int TAIL_CYCLES = 8;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_char_in;
   logic       req_end_of_input;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_char_out;
   logic [2:0] rsp_token_kind;
   logic       rsp_token_end;
   logic       csr_write_en;
   logic [8:0] csr_write_data;

   // Scanner copy kept by the bench
   mode_type          lex_mode;
   logic [7:0]        pend_char;
   logic              pend_valid;
   logic [2:0]        pend_kind;
   logic [7:0]        last_char;
   logic              quote_sq;
   logic [LimitW-1:0] run_len;
   logic [LimitW-1:0] limit_reg;

   result_type token_chars_due[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int bytes_sent = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   c_source_token_splitter_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_in      (req_char_in),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_char_out     (rsp_char_out),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_end    (rsp_token_end),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- character classes

   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_word(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER || c == CH_DOT;
   endfunction

   function automatic bit is_blank(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
   endfunction

   // ---------------------------------------------------------------- token predictor

   task automatic reset_scanner();
      lex_mode   = MODE_IDLE;
      pend_char  = 8'd0;
      pend_valid = 1'b0;
      pend_kind  = KIND_WORD;
      last_char  = 8'd0;
      quote_sq   = 1'b0;
      run_len    = '0;
      limit_reg  = TOKEN_LIMIT_RESET;
   endtask

   task automatic emit_char(input logic [7:0] ch, input logic [2:0] kind, input logic last);
      result_type r;
      r.char_out   = ch;
      r.token_kind = kind;
      r.token_end  = last;
      token_chars_due.push_back(r);
   endtask

   // Add one character to the open token; release the held one, hold or close this one
   task automatic extend_token(input logic [7:0] ch, input logic [2:0] kind, input bit closes);
      logic [LimitW-1:0] lim;
      lim = (limit_reg < TOKEN_LIMIT_MIN) ? TOKEN_LIMIT_MIN : limit_reg;
      if (pend_valid) emit_char(pend_char, pend_kind, 1'b0);
      run_len = run_len + 1'b1;
      if (closes || run_len >= lim - 9'd1) begin
         // closing quote, or the token is full: end it here
         emit_char(ch, kind, 1'b1);
         pend_valid = 1'b0;
         lex_mode   = MODE_IDLE;
         run_len    = '0;
      end else begin
         pend_char  = ch;
         pend_kind  = kind;
         pend_valid = 1'b1;
      end
   endtask

   // Classify a byte that starts a fresh token
   task automatic open_token(input logic [7:0] c);
      pend_valid = 1'b0;
      run_len    = '0;
      lex_mode   = MODE_IDLE;
      if (is_blank(c)) begin
         // drop whitespace
      end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
         lex_mode  = MODE_STRING;
         quote_sq  = (c == CH_SQUOTE);
         last_char = c;
         extend_token(c, KIND_STRING, 1'b0);
      end else if (c == CH_SLASH) begin
         lex_mode = MODE_SLASH;
      end else if (is_digit(c)) begin
         lex_mode  = MODE_NUMBER;
         last_char = c;
         extend_token(c, KIND_NUMBER, 1'b0);
      end else if (is_word(c)) begin
         lex_mode  = MODE_WORD;
         last_char = c;
         extend_token(c, KIND_WORD, 1'b0);
      end else begin
         emit_char(c, KIND_SINGLE, 1'b1);
      end
   endtask

   task automatic flush_and_reopen(input logic [7:0] c);
      if (pend_valid) emit_char(pend_char, pend_kind, 1'b1);
      pend_valid = 1'b0;
      open_token(c);
   endtask

   // Work out the beats that one accepted source byte causes
   task automatic split_byte(input logic [7:0] c, input bit eoi);
      bit closes;
      if (eoi) begin
         // flush held character, then a pending slash, then the end marker
         if (pend_valid) emit_char(pend_char, pend_kind, 1'b1);
         if (lex_mode == MODE_SLASH) emit_char(CH_SLASH, KIND_SINGLE, 1'b1);
         emit_char(CH_NUL, KIND_END, 1'b1);
         lex_mode   = MODE_IDLE;
         pend_valid = 1'b0;
         run_len    = '0;
         last_char  = 8'd0;
      end else begin
         case (lex_mode)
            MODE_WORD: begin
               if (is_word(c)) begin
                  last_char = c;
                  extend_token(c, KIND_WORD, 1'b0);
               end else flush_and_reopen(c);
            end
            MODE_NUMBER: begin
               if (is_digit(c) || ((c == CH_COMMA || c == CH_DOT) && is_digit(last_char))) begin
                  last_char = c;
                  extend_token(c, KIND_NUMBER, 1'b0);
               end else flush_and_reopen(c);
            end
            MODE_STRING: begin
               // only an unescaped quote of the opening kind closes
               closes    = (c == (quote_sq ? CH_SQUOTE : CH_DQUOTE)) && (last_char != CH_BSLASH);
               last_char = c;
               extend_token(c, KIND_STRING, closes);
            end
            MODE_SLASH: begin
               if (c == CH_SLASH) begin
                  lex_mode = MODE_LINE;
               end else if (c == CH_STAR) begin
                  lex_mode  = MODE_BLOCK;
                  last_char = 8'd0;
               end else begin
                  emit_char(CH_SLASH, KIND_SINGLE, 1'b1);
                  open_token(c);
               end
            end
            MODE_LINE: begin
               if (c == CH_NL) open_token(c);
            end
            MODE_BLOCK: begin
               // the star must come after the opening star
               if (last_char == CH_STAR && c == CH_SLASH) begin
                  lex_mode  = MODE_IDLE;
                  last_char = 8'd0;
               end else last_char = c;
            end
            default: open_token(c);
         endcase
      end
   endtask

   // ---------------------------------------------------------------- drivers

   // Offer one source beat, idling at random first, and predict it once accepted
   task automatic send_beat(input logic [7:0] ch, input bit eoi);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_char_in      <= ch;
      req_end_of_input <= eoi;
      do @(posedge clock); while (!req_ready);
      split_byte(ch, eoi);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
   endtask

   // Drop valid and hold until every due beat has arrived and the pipe has settled
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (token_chars_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_token_limit(input logic [8:0] value);
      drain_results();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      limit_reg = value;
   endtask

   // Result side: stall at random on the falling edge
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   always @(posedge clock) begin : check_beats
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (token_chars_due.size() == 0) begin
            report_mismatch($sformatf("beat with nothing due: char %02h kind %0d end %0b",
                                      rsp_char_out, rsp_token_kind, rsp_token_end));
         end else begin
            want = token_chars_due.pop_front();
            if (rsp_char_out !== want.char_out)
               report_mismatch($sformatf("char_out %02h, want %02h",
                                         rsp_char_out, want.char_out));
            if (rsp_token_kind !== want.token_kind)
               report_mismatch($sformatf("token_kind %0d, want %0d",
                                         rsp_token_kind, want.token_kind));
            if (rsp_token_end !== want.token_end)
               report_mismatch($sformatf("token_end %0b, want %0b",
                                         rsp_token_end, want.token_end));
         end
      end
   end

   // Watchdog: end the run once neither channel has moved a beat for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- random source text

   function automatic logic [7:0] rand_word_char();
      int r;
      r = $urandom_range(0, 53);
      if (r < 26) return 8'("a" + r);
      else if (r < 52) return 8'("A" + (r - 26));
      else if (r == 52) return CH_UNDER;
      else return CH_DOT;
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'("0" + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_printable();
      return 8'($urandom_range(8'h20, 8'h7E));
   endfunction

   // Send one fragment of C-like text; mostly well formed, some noise and broken tails
   task automatic send_fragment();
      int pick;
      int len;
      int i;
      logic [7:0] q;
      string punct;
      punct = "+-=;(){}[]<>!&|^%~?:#";
      pick  = $urandom_range(0, 99);
      if (pick < 24) begin
         // word, now and then long enough to hit the limit
         len = ($urandom_range(0, 29) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 10);
         for (i = 0; i < len; i++) send_beat(rand_word_char(), 1'b0);
      end else if (pick < 38) begin
         send_beat(rand_digit(), 1'b0);
         len = $urandom_range(0, 8);
         for (i = 0; i < len; i++)
            send_beat(($urandom_range(0, 4) == 0) ?
                      ($urandom_range(0, 1) ? CH_COMMA : CH_DOT) : rand_digit(), 1'b0);
      end else if (pick < 48) begin
         q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
         send_beat(q, 1'b0);
         len = $urandom_range(0, 10);
         for (i = 0; i < len; i++) begin
            case ($urandom_range(0, 5))
               0: begin
                  send_beat(CH_BSLASH, 1'b0);
                  send_beat(q, 1'b0);
               end
               1: send_beat((q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE, 1'b0);
               2: send_beat(CH_BSLASH, 1'b0);
               default: send_beat(rand_printable(), 1'b0);
            endcase
         end
         if ($urandom_range(0, 9) != 0) send_beat(q, 1'b0);
      end else if (pick < 56) begin
         case ($urandom_range(0, 4))
            0: send_beat(CH_SPACE, 1'b0);
            1: send_beat(CH_TAB, 1'b0);
            2: send_beat(CH_VT, 1'b0);
            3: send_beat(CH_FF, 1'b0);
            default: send_beat(CH_CR, 1'b0);
         endcase
      end else if (pick < 61) begin
         send_beat(CH_NL, 1'b0);
      end else if (pick < 68) begin
         send_beat(CH_SLASH, 1'b0);
         send_beat(CH_SLASH, 1'b0);
         len = $urandom_range(0, 8);
         for (i = 0; i < len; i++) send_beat(8'($urandom_range(0, 255)), 1'b0);
         send_beat(CH_NL, 1'b0);
      end else if (pick < 75) begin
         send_beat(CH_SLASH, 1'b0);
         send_beat(CH_STAR, 1'b0);
         len = $urandom_range(0, 8);
         for (i = 0; i < len; i++) begin
            case ($urandom_range(0, 3))
               0: send_beat(CH_STAR, 1'b0);
               1: send_beat(CH_SLASH, 1'b0);
               default: send_beat(rand_printable(), 1'b0);
            endcase
         end
         send_beat(CH_STAR, 1'b0);
         send_beat(CH_SLASH, 1'b0);
      end else if (pick < 80) begin
         send_beat(CH_SLASH, 1'b0);
      end else if (pick < 88) begin
         send_beat(punct[$urandom_range(0, punct.len() - 1)], 1'b0);
      end else if (pick < 94) begin
         send_beat(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 97) begin
         send_beat(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         // open comment or string cut short by the end of the stream
         if ($urandom_range(0, 1)) begin
            send_beat(CH_SLASH, 1'b0);
            send_beat(CH_STAR, 1'b0);
         end else send_beat($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE, 1'b0);
         len = $urandom_range(0, 5);
         for (i = 0; i < len; i++) send_beat(rand_printable(), 1'b0);
         send_beat(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_words_and_numbers();
      // letter extremes, underscore, dot; comma and dot after a digit, then a stray comma
      send_text("z_A.0,9., ");
   endtask

   task automatic test_strings();
      // escaped quote stays inside; a double quote does not close a single-quoted string
      send_text("\"\\\"\"'\"'");
   endtask

   task automatic test_comments_and_slash();
      // star-slash sharing the opening star must not close the block comment
      send_text("/*/*/");
      send_text("//\t\n");
      send_text("/a");
      // end of stream with a slash still pending
      send_beat(CH_SLASH, 1'b0);
      send_beat(8'hFF, 1'b1);
   endtask

   task automatic test_high_bytes_and_end();
      send_beat(8'h80, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(CH_NUL, 1'b0);
      // end of stream releases the held character as a token end
      send_text("ab");
      send_beat(8'h00, 1'b1);
   endtask

   task automatic test_token_limit_extremes();
      // below range acts as two: every character is a token of its own
      write_token_limit(9'd0);
      send_text("ab\"x");
      write_token_limit(9'd3);
      send_text("abc12345");
      write_token_limit(TOKEN_LIMIT_RESET);
   endtask

   task automatic test_random_traffic(input logic [8:0] limit, input int s_pct,
                                      input int r_pct, input int count);
      int target;
      write_token_limit(limit);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      target = bytes_sent + count;
      while (bytes_sent < target) send_fragment();
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_char_in      = 8'd0;
      req_end_of_input = 1'b0;
      csr_write_en     = 1'b0;
      csr_write_data   = 9'd0;
      reset_scanner();
      send_idle_pct = 35;
      recv_idle_pct = 82;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      test_words_and_numbers();
      test_strings();
      test_comments_and_slash();
      test_high_bytes_and_end();
      test_token_limit_extremes();
      test_random_traffic(9'd256, 35, 82, 170);
      test_random_traffic(9'd6, 82, 35, 170);
      test_random_traffic(9'd511, 0, 0, 110);
      test_random_traffic(9'd1, 0, 0, 50);

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/tsplit_pkg.sv
hdl/tsplit_step.sv
hdl/tsplit_rsp_fifo.sv
hdl/c_source_token_splitter_unit.sv
bench/tb_top.sv
